### rtl/nfws_pkg.sv
package nfws_pkg;

	localparam int MAX_WAYPOINTS = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int ROOT_W = 34;
	localparam int DIR_W = 18;
	localparam int ONE_Q16 = 65536;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [32:0] diff_t;
	typedef logic signed [65:0] prod_t;
	typedef logic [67:0] wide_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		logic found;
		logic [IDX_W-1:0] index;
		wide_t d2;
		wide_t l2;
		diff_t dx;
		diff_t dy;
		diff_t dz;
		point_t pos;
	} best_t;

	typedef enum logic [1:0] {
		REG_COUNT = 2'd0,
		REG_END_X = 2'd1,
		REG_END_Y = 2'd2,
		REG_END_Z = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ROOT,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	function automatic wide_t sext_prod(prod_t p);
		return {{2{p[65]}}, p};
	endfunction

	function automatic diff_t sub_ext(coord_t a, coord_t b);
		return {a[31], a} - {b[31], b};
	endfunction

endpackage

### rtl/nfws_sqrt.sv
module nfws_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  nfws_pkg::wide_t            value,
	output logic                       done,
	output logic [nfws_pkg::ROOT_W-1:0] root
);
	import nfws_pkg::*;

	logic [67:0] val_q;
	logic [36:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [36:0] rem_t;
	logic [36:0] trial;

	assign rem_t = {rem_q[34:0], val_q[67:66]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one result bit per cycle, two radicand bits consumed
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[65:0], 2'b00};
			if (rem_t >= trial) begin
				rem_q <= rem_t - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_t;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/nfws_div.sv
module nfws_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  nfws_pkg::diff_t                   delta,
	input  logic [nfws_pkg::ROOT_W-1:0]       len,
	output logic                              done,
	output logic signed [nfws_pkg::DIR_W-1:0] comp
);
	import nfws_pkg::*;

	logic [49:0] rem_q;
	logic [50:0] dsr_q;
	logic [DIR_W-1:0] quo_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic neg_q;
	logic zero_q;
	logic [32:0] mag;
	logic [DIR_W-1:0] sat;

	assign mag = delta[32] ? 33'(-delta) : 33'(delta);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(DIR_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring divide, rounding bias added up front
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, mag, 16'b0} + 50'(len[ROOT_W-1:1]);
			dsr_q <= {len, 17'b0};
			quo_q <= '0;
			neg_q <= delta[32];
			zero_q <= (len == '0);
		end else if (busy_q) begin
			dsr_q <= dsr_q >> 1;
			if ({1'b0, rem_q} >= dsr_q) begin
				rem_q <= 50'({1'b0, rem_q} - dsr_q);
				quo_q <= {quo_q[DIR_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[DIR_W-2:0], 1'b0};
			end
		end
	end

	assign sat = (quo_q > DIR_W'(ONE_Q16)) ? DIR_W'(ONE_Q16) : quo_q;
	assign comp = zero_q ? '0 : (neg_q ? -$signed(sat) : $signed(sat));
	assign done = done_q;

endmodule

### rtl/nfws_search.sv
module nfws_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [nfws_pkg::IDX_W-1:0]     wr_addr,
	input  nfws_pkg::point_t               wr_data,
	input  logic                           start,
	input  nfws_pkg::point_t               query,
	input  logic [nfws_pkg::CNT_W-1:0]     count,
	input  nfws_pkg::point_t               end_pt,
	output logic                           done,
	output nfws_pkg::best_t                best
);
	import nfws_pkg::*;

	point_t mem [MAX_WAYPOINTS];
	point_t rdata_q;
	point_t prev_q;
	point_t query_q;
	logic [CNT_W-1:0] n_lim;
	logic [CNT_W-1:0] rd_cnt_q;
	logic rd_busy_q, rvalid_q, rlast_q, have_prev_q, tail_q;
	logic [IDX_W-1:0] e_idx_q;
	logic emit_v;
	point_t nxt;

	logic v_s1, last_s1, v_s2, last_s2, v_s3, last_s3;
	diff_t dx_s1, dy_s1, dz_s1, vx_s1, vy_s1, vz_s1;
	diff_t dx_s2, dy_s2, dz_s2, dx_s3, dy_s3, dz_s3;
	point_t pos_s1, pos_s2, pos_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	prod_t pdx_s2, pdy_s2, pdz_s2, pvx_s2, pvy_s2, pvz_s2, plx_s2, ply_s2, plz_s2;
	wide_t dot_s3, d2_s3, l2_s3;
	best_t best_q;
	logic done_q;

	assign n_lim = (count > CNT_W'(MAX_WAYPOINTS)) ? CNT_W'(MAX_WAYPOINTS) : count;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_cnt_q[IDX_W-1:0]];
	end

	// walk the store: entry i is scored once entry i+1 (or the end point) is in hand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_busy_q <= 1'b0;
			rd_cnt_q <= '0;
			rvalid_q <= 1'b0;
			rlast_q <= 1'b0;
			have_prev_q <= 1'b0;
			tail_q <= 1'b0;
			e_idx_q <= '0;
		end else begin
			rvalid_q <= rd_busy_q;
			rlast_q <= rd_busy_q && (rd_cnt_q == n_lim - CNT_W'(1));
			tail_q <= rvalid_q && rlast_q;
			if (start) begin
				rd_busy_q <= (n_lim != '0);
				rd_cnt_q <= '0;
				have_prev_q <= 1'b0;
				e_idx_q <= '0;
			end else begin
				if (rd_busy_q) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					if (rd_cnt_q == n_lim - CNT_W'(1)) begin
						rd_busy_q <= 1'b0;
					end
				end
				if (rvalid_q) begin
					have_prev_q <= 1'b1;
				end
				if (emit_v) begin
					e_idx_q <= e_idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			query_q <= query;
		end
		if (rvalid_q) begin
			prev_q <= rdata_q;
		end
	end

	assign emit_v = (rvalid_q && have_prev_q) || tail_q;
	assign nxt = tail_q ? end_pt : rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			v_s2 <= 1'b0;
			last_s2 <= 1'b0;
			v_s3 <= 1'b0;
			last_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= emit_v;
			last_s1 <= tail_q;
			v_s2 <= v_s1;
			last_s2 <= last_s1;
			v_s3 <= v_s2;
			last_s3 <= last_s2;
			done_q <= (start && (n_lim == '0)) || (v_s3 && last_s3);
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= sub_ext(nxt.x, prev_q.x);
		dy_s1 <= sub_ext(nxt.y, prev_q.y);
		dz_s1 <= sub_ext(nxt.z, prev_q.z);
		vx_s1 <= sub_ext(query_q.x, prev_q.x);
		vy_s1 <= sub_ext(query_q.y, prev_q.y);
		vz_s1 <= sub_ext(query_q.z, prev_q.z);
		pos_s1 <= prev_q;
		idx_s1 <= e_idx_q;

		pdx_s2 <= dx_s1 * vx_s1;
		pdy_s2 <= dy_s1 * vy_s1;
		pdz_s2 <= dz_s1 * vz_s1;
		pvx_s2 <= vx_s1 * vx_s1;
		pvy_s2 <= vy_s1 * vy_s1;
		pvz_s2 <= vz_s1 * vz_s1;
		plx_s2 <= dx_s1 * dx_s1;
		ply_s2 <= dy_s1 * dy_s1;
		plz_s2 <= dz_s1 * dz_s1;
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		dz_s2 <= dz_s1;
		pos_s2 <= pos_s1;
		idx_s2 <= idx_s1;

		dot_s3 <= sext_prod(pdx_s2) + sext_prod(pdy_s2) + sext_prod(pdz_s2);
		d2_s3 <= sext_prod(pvx_s2) + sext_prod(pvy_s2) + sext_prod(pvz_s2);
		l2_s3 <= sext_prod(plx_s2) + sext_prod(ply_s2) + sext_prod(plz_s2);
		dx_s3 <= dx_s2;
		dy_s3 <= dy_s2;
		dz_s3 <= dz_s2;
		pos_s3 <= pos_s2;
		idx_s3 <= idx_s2;

		// strict compare keeps the lower index on a tie
		if (start) begin
			best_q.found <= 1'b0;
		end else if (v_s3 && !dot_s3[67] && (!best_q.found || (d2_s3 < best_q.d2))) begin
			best_q.found <= 1'b1;
			best_q.index <= idx_s3;
			best_q.d2 <= d2_s3;
			best_q.l2 <= l2_s3;
			best_q.dx <= dx_s3;
			best_q.dy <= dy_s3;
			best_q.dz <= dz_s3;
			best_q.pos <= pos_s3;
		end
	end

	assign done = done_q;
	assign best = best_q;

endmodule

### rtl/nearest_forward_waypoint_search.sv
// Load request: written into the store when accepted, no result.
// Query request: walks the store (one entry per cycle through its single read
// port); if a waypoint qualifies, bit-serial square roots and bit-serial divides
// follow; then the result is loaded into the output register.
// One request is in work at a time; a finished result may wait in the output register.
// arst_n clears control state, the count and the end point; the store is undefined until loaded.
module nearest_forward_waypoint_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [103:0]  s_tdata,  // entry_index, coord_x, coord_y, coord_z, zero pad
	input  logic          s_tuser,  // func
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [191:0]  m_tdata,  // best_index, best_distance, dir_x, dir_y, dir_z,
	                                // pos_x, pos_y, pos_z, zero pad
	output logic          m_tuser,  // found
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import nfws_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	point_t end_q;
	point_t in_pt;
	logic in_acc;
	logic start_search, start_root, start_div, load_out;
	logic srch_done;
	best_t best;
	logic root_done, len_done;
	logic [ROOT_W-1:0] dist_root, len_root;
	logic div_done_x, div_done_y, div_done_z;
	logic signed [DIR_W-1:0] cx, cy, cz;
	logic m_tvalid_q;
	logic [191:0] m_tdata_q;
	logic m_tuser_q;
	logic [191:0] out_data;

	assign in_pt.x = s_tdata[37:6];
	assign in_pt.y = s_tdata[69:38];
	assign in_pt.z = s_tdata[101:70];
	assign in_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			end_q <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_COUNT: count_q <= cfg_data[CNT_W-1:0];
				REG_END_X: end_q.x <= cfg_data;
				REG_END_Y: end_q.y <= cfg_data;
				REG_END_Z: end_q.z <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (s_tuser == FUNC_QUERY)) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (srch_done) state_d = best.found ? ST_ROOT : ST_EMIT;
			end
			ST_ROOT: begin
				if (root_done && len_done) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_done_x && div_done_y && div_done_z) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		start_search = 1'b0;
		start_root = 1'b0;
		start_div = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				start_search = s_tvalid && (s_tuser == FUNC_QUERY);
			end
			ST_SEARCH: start_root = srch_done && best.found;
			ST_ROOT: start_div = root_done && len_done;
			ST_EMIT: load_out = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	nfws_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_acc && (s_tuser == FUNC_LOAD)),
		.wr_addr (s_tdata[IDX_W-1:0]),
		.wr_data (in_pt),
		.start   (start_search),
		.query   (in_pt),
		.count   (count_q),
		.end_pt  (end_q),
		.done    (srch_done),
		.best    (best)
	);

	nfws_sqrt u_sqrt_dist (
		.clk (clk), .arst_n (arst_n), .start (start_root),
		.value (best.d2), .done (root_done), .root (dist_root)
	);

	nfws_sqrt u_sqrt_len (
		.clk (clk), .arst_n (arst_n), .start (start_root),
		.value (best.l2), .done (len_done), .root (len_root)
	);

	nfws_div u_div_x (
		.clk (clk), .arst_n (arst_n), .start (start_div),
		.delta (best.dx), .len (len_root), .done (div_done_x), .comp (cx)
	);

	nfws_div u_div_y (
		.clk (clk), .arst_n (arst_n), .start (start_div),
		.delta (best.dy), .len (len_root), .done (div_done_y), .comp (cy)
	);

	nfws_div u_div_z (
		.clk (clk), .arst_n (arst_n), .start (start_div),
		.delta (best.dz), .len (len_root), .done (div_done_z), .comp (cz)
	);

	// all fields read zero when nothing qualifies
	always_comb begin
		out_data = '0;
		if (best.found) begin
			out_data = {2'b00, best.pos.z, best.pos.y, best.pos.x, cz, cy, cx,
				dist_root, best.index};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= out_data;
			m_tuser_q <= best.found;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

### verif/nearest_forward_waypoint_search_tb.sv
`timescale 1ns / 1ps

module nearest_forward_waypoint_search_tb;
	import nfws_pkg::*;

	typedef struct packed {
		logic found;
		logic [5:0] index;
		logic [33:0] distance;
		logic [17:0] dx;
		logic [17:0] dy;
		logic [17:0] dz;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} hit_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [103:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [191:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	nearest_forward_waypoint_search uut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic signed [31:0] path_x [MAX_WAYPOINTS];
	logic signed [31:0] path_y [MAX_WAYPOINTS];
	logic signed [31:0] path_z [MAX_WAYPOINTS];
	bit written [MAX_WAYPOINTS];
	int path_len = 0;
	logic signed [31:0] goal_x = 0, goal_y = 0, goal_z = 0;

	hit_t expected_hits [$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 0;   // no random gaps
	bit hold_off = 0;

	function automatic logic [33:0] isqrt(logic [67:0] v);
		logic [33:0] r;
		logic [33:0] c;
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (34'd1 << b);
			if ({68'd0, c} * {68'd0, c} <= {68'd0, v}) r = c;
		end
		return r;
	endfunction

	function automatic logic [17:0] unit_part(logic signed [32:0] d, logic [33:0] len);
		logic [67:0] m;
		logic [67:0] q;
		logic signed [17:0] s;
		if (len == 0) return '0;
		m = d < 0 ? 68'(-d) : 68'(d);
		q = ((m << 16) + (len >> 1)) / len;
		if (q > ONE_Q16) q = ONE_Q16;
		s = 18'(q);
		return d < 0 ? -s : s;
	endfunction

	function automatic hit_t search_path(logic signed [31:0] qx, qy, qz);
		hit_t h;
		logic signed [32:0] dx, dy, dz, vx, vy, vz, bx, by, bz;
		logic signed [67:0] dot;
		logic [67:0] d2, best_d2, l2;
		logic [33:0] len;
		int n;
		h = '0;
		best_d2 = 0;
		bx = 0; by = 0; bz = 0;
		n = path_len > MAX_WAYPOINTS ? MAX_WAYPOINTS : path_len;
		for (int i = 0; i < n; i++) begin
			if (i + 1 < n) begin
				dx = path_x[i+1] - 33'(path_x[i]);
				dy = path_y[i+1] - 33'(path_y[i]);
				dz = path_z[i+1] - 33'(path_z[i]);
			end else begin
				dx = goal_x - 33'(path_x[i]);
				dy = goal_y - 33'(path_y[i]);
				dz = goal_z - 33'(path_z[i]);
			end
			vx = qx - 33'(path_x[i]);
			vy = qy - 33'(path_y[i]);
			vz = qz - 33'(path_z[i]);
			dot = 68'(dx) * 68'(vx) + 68'(dy) * 68'(vy) + 68'(dz) * 68'(vz);
			if (dot < 0) continue;
			d2 = 68'(68'(vx) * 68'(vx) + 68'(vy) * 68'(vy) + 68'(vz) * 68'(vz));
			if (!h.found || d2 < best_d2) begin
				h.found = 1;
				best_d2 = d2;
				h.index = 6'(i);
				bx = dx; by = dy; bz = dz;
			end
		end
		if (h.found) begin
			l2 = 68'(68'(bx) * 68'(bx) + 68'(by) * 68'(by) + 68'(bz) * 68'(bz));
			len = isqrt(l2);
			h.distance = isqrt(best_d2);
			h.dx = unit_part(bx, len);
			h.dy = unit_part(by, len);
			h.dz = unit_part(bz, len);
			h.px = path_x[h.index];
			h.py = path_y[h.index];
			h.pz = path_z[h.index];
		end
		return h;
	endfunction

	// returns right after the accepting edge; the next caller or drain drops valid
	task automatic send_request(logic func, logic [5:0] idx, logic [31:0] x, y, z);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 14) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= func;
		s_tdata <= {2'b00, z, y, x, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (func == FUNC_QUERY) expected_hits = {expected_hits, search_path(x, y, z)};
		else begin
			path_x[idx] = x; path_y[idx] = y; path_z[idx] = z;
			written[idx] = 1;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 0;
		while (expected_hits.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		cfg_valid <= 1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (r)
			REG_COUNT: path_len = v[6:0];
			REG_END_X: goal_x = v;
			REG_END_Y: goal_y = v;
			REG_END_Z: goal_z = v;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_path(int n, logic [31:0] ex, ey, ez);
		drain();
		write_reg(REG_COUNT, n);
		write_reg(REG_END_X, ex);
		write_reg(REG_END_Y, ey);
		write_reg(REG_END_Z, ez);
		cfg_valid <= 0;
	endtask

	function automatic logic [31:0] rand_coord(int spread);
		case (spread)
			0: return $urandom();
			1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			default: return 32'($signed($urandom_range(200000)) - 100000);
		endcase
	endfunction

	task automatic load_path(int n, int spread);
		for (int i = 0; i < n; i++)
			send_request(FUNC_LOAD, 6'(i), rand_coord(spread), rand_coord(spread),
				rand_coord(spread));
	endtask

	task automatic test_directed();
		// empty path: nothing qualifies
		send_request(FUNC_QUERY, 6'd5, 32'h7fffffff, 32'h80000000, 0);
		send_request(FUNC_LOAD, 6'd0, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(FUNC_LOAD, 6'd1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_request(FUNC_LOAD, 6'd63, 32'h7fffffff, 32'h80000000, 0);
		set_path(2, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_request(FUNC_QUERY, 6'd63, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_request(FUNC_QUERY, 0, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(FUNC_QUERY, 0, 32'h80000000, 32'h7fffffff, 32'h80000000);
		// zero-length direction: last waypoint sits on the end point
		set_path(2, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_request(FUNC_QUERY, 0, 0, 0, 0);
		// equal distances to both waypoints; only the lower index lies ahead, so it wins
		send_request(FUNC_LOAD, 6'd0, 32'h00010000, 0, 0);
		send_request(FUNC_LOAD, 6'd1, 32'hffff0000, 0, 0);
		set_path(2, 32'hfffe0000, 0, 0);
		send_request(FUNC_QUERY, 0, 0, 0, 0);
		send_request(FUNC_QUERY, 0, 0, 32'h00050000, 0);
		// count beyond capacity
		load_path(64, 1);
		set_path(127, 0, 0, 0);
		send_request(FUNC_QUERY, 0, 0, 0, 0);
		send_request(FUNC_QUERY, 0, 32'h01000000, 32'hff000000, 32'h00300000);
		set_path(64, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_request(FUNC_QUERY, 0, 32'h80000000, 32'h7fffffff, 32'h80000000);
	endtask

	task automatic test_random(int rounds);
		int n, spread, q;
		for (int r = 0; r < rounds; r++) begin
			n = ($urandom_range(7) == 0) ? $urandom_range(64, 40) : $urandom_range(8, 1);
			spread = $urandom_range(2);
			load_path(n, spread);
			set_path($urandom_range(9) == 0 ? $urandom_range(127, 65) : n,
				rand_coord(spread), rand_coord(spread), rand_coord(spread));
			q = $urandom_range(10, 3);
			for (int k = 0; k < q; k++) begin
				if ($urandom_range(9) == 0)
					// reload an entry already in use
					send_request(FUNC_LOAD, 6'($urandom_range(n - 1)), rand_coord(spread),
						rand_coord(spread), rand_coord(spread));
				else
					send_request(FUNC_QUERY, 6'($urandom()), rand_coord(spread),
						rand_coord(spread), rand_coord(spread));
			end
		end
	endtask

	task automatic test_backpressure();
		load_path(3, 2);
		set_path(3, 0, 0, 0);
		hold_off = 1;
		for (int k = 0; k < 6; k++)
			send_request(FUNC_QUERY, 0, rand_coord(2), rand_coord(2), rand_coord(2));
		@(negedge clk);
		s_tvalid <= 0;
		wait (hold_off == 0);
	endtask

	// receiver
	always @(negedge clk) begin
		if (hold_off) begin
			m_tready <= 0;
			repeat (600) @(negedge clk);
			hold_off <= 0;
		end else
			m_tready <= quiet || ($urandom_range(99) >= 14);
	end

	always @(posedge clk) begin
		hit_t h;
		hit_t want;
		if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (m_tvalid && m_tready) begin
			h.found = m_tuser;
			{h.pz, h.py, h.px, h.dz, h.dy, h.dx, h.distance, h.index} = m_tdata[189:0];
			if (expected_hits.size() == 0) begin
				$display("%0t: unexpected result found=%0d index=%0d", $time, h.found, h.index);
				errors++;
			end else begin
				want = expected_hits.pop_front();
				if (h !== want) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, h);
					errors++;
				end
			end
		end
		if (idle_cycles > 20000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random(25);
		quiet = 1;
		test_random(25);
		quiet = 0;
		test_random(36);
		drain();
		if (errors == 0 && expected_hits.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
